>>> hw/rtl/seeo_pkg.sv
// shared constants, codes and types for the stack engine
package seeo_pkg;

    // stack geometry
    localparam int DEPTH  = 128;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;
    localparam int OCC_W  = 8;

    // opcodes
    localparam logic [OP_W-1:0] OP_PUSH          = 3'd0;
    localparam logic [OP_W-1:0] OP_POP           = 3'd1;
    localparam logic [OP_W-1:0] OP_REVERSE       = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE_BOTTOM = 3'd3;
    localparam logic [OP_W-1:0] OP_SWAP_ENDS     = 3'd4;
    localparam logic [OP_W-1:0] OP_PUSH_SUM      = 3'd5;

    // status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_SUM = 2'd3;

    // memory port request from the sequencer
    typedef struct packed {
        logic              we;
        logic [PTR_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [PTR_W-1:0]  raddr;
    } mem_req_t;

    // finished result of one transaction
    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [ST_W-1:0]          status;
        logic [OCC_W-1:0]         occupancy;
    } result_t;

endpackage

>>> hw/rtl/seeo_ram.sv
// generic single-write, single-read ram with registered read data
module seeo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/seeo_alu.sv
// shared adder and equality compare used by the sequencer
module seeo_alu
    import seeo_pkg::*;
(
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output logic [DATA_W-1:0] sum,
    output logic              eq
);

    // wrapping add and word compare
    assign sum = a + b;
    assign eq  = (a == b);

endmodule

>>> hw/rtl/seeo_ctrl.sv
// sequencer that walks the stack memory for each operation
module seeo_ctrl
    import seeo_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   opcode,
    input  logic [DATA_W-1:0] value,
    input  logic              out_free,
    output logic              done,
    output result_t           rslt,
    output mem_req_t          mem,
    input  logic [DATA_W-1:0] rdata,
    output logic [DATA_W-1:0] alu_a,
    output logic [DATA_W-1:0] alu_b,
    input  logic [DATA_W-1:0] alu_sum,
    input  logic              alu_eq
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_POP_RD = 4'd2;
    localparam logic [3:0] S_SW_RA  = 4'd3;
    localparam logic [3:0] S_SW_RB  = 4'd4;
    localparam logic [3:0] S_SW_WA  = 4'd5;
    localparam logic [3:0] S_SW_WB  = 4'd6;
    localparam logic [3:0] S_RM_RD  = 4'd7;
    localparam logic [3:0] S_RM_WR  = 4'd8;
    localparam logic [3:0] S_SUM    = 4'd9;
    localparam logic [3:0] S_FINISH = 4'd10;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [3:0]        state_reg, state_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PTR_W-1:0]  lo_reg, lo_next;
    logic [PTR_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [DATA_W-1:0] tmp_reg, tmp_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic [ST_W-1:0]   st_reg, st_next;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        val_reg <= val_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        idx_reg <= idx_next;
        tmp_reg <= tmp_next;
        res_reg <= res_next;
        st_reg  <= st_next;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        val_next   = val_reg;
        cnt_next   = cnt_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        tmp_next   = tmp_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        in_ready   = 1'b0;
        done       = 1'b0;
        mem        = '0;
        alu_a      = res_reg;
        alu_b      = rdata;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next    = opcode;
                    val_next   = value;
                    res_next   = '0;
                    st_next    = ST_OK;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_FINISH;
                unique case (op_reg)
                    OP_PUSH:
                    begin
                        if (cnt_reg == CNT_FULL)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            mem.we    = 1'b1;
                            mem.waddr = cnt_reg[PTR_W-1:0];
                            mem.wdata = val_reg;
                            cnt_next  = cnt_reg + 1'b1;
                        end
                    end
                    OP_POP:
                    begin
                        if (cnt_reg == '0)
                        begin
                            st_next = ST_EMPTY;
                        end
                        else
                        begin
                            mem.raddr  = PTR_W'(cnt_reg - 1'b1);
                            cnt_next   = cnt_reg - 1'b1;
                            state_next = S_POP_RD;
                        end
                    end
                    OP_REVERSE:
                    begin
                        if (cnt_reg > CNT_W'(1))
                        begin
                            lo_next    = '0;
                            hi_next    = PTR_W'(cnt_reg - 1'b1);
                            state_next = S_SW_RA;
                        end
                    end
                    OP_REMOVE_BOTTOM:
                    begin
                        if (cnt_reg == '0)
                        begin
                            st_next = ST_EMPTY;
                        end
                        else if (cnt_reg == CNT_W'(1))
                        begin
                            cnt_next = '0;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_RM_RD;
                        end
                    end
                    OP_SWAP_ENDS:
                    begin
                        if (cnt_reg == '0)
                        begin
                            st_next = ST_EMPTY;
                        end
                        else if (cnt_reg > CNT_W'(1))
                        begin
                            lo_next    = '0;
                            hi_next    = PTR_W'(cnt_reg - 1'b1);
                            state_next = S_SW_RA;
                        end
                    end
                    OP_PUSH_SUM:
                    begin
                        res_next   = '0;
                        idx_next   = '0;
                        pend_next  = 1'b0;
                        state_next = S_SUM;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            // popped word arrives from the ram
            S_POP_RD:
            begin
                res_next   = rdata;
                state_next = S_FINISH;
            end

            // swap of two entries: read low, read high, write both
            S_SW_RA:
            begin
                mem.raddr  = lo_reg;
                state_next = S_SW_RB;
            end

            S_SW_RB:
            begin
                mem.raddr  = hi_reg;
                tmp_next   = rdata;
                state_next = S_SW_WA;
            end

            S_SW_WA:
            begin
                mem.we     = 1'b1;
                mem.waddr  = lo_reg;
                mem.wdata  = rdata;
                state_next = S_SW_WB;
            end

            S_SW_WB:
            begin
                mem.we    = 1'b1;
                mem.waddr = hi_reg;
                mem.wdata = tmp_reg;
                lo_next   = lo_reg + 1'b1;
                hi_next   = hi_reg - 1'b1;
                if ((op_reg == OP_REVERSE) && (lo_next < hi_next))
                begin
                    state_next = S_SW_RA;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            // shift down by one: read entry above, write it one lower
            S_RM_RD:
            begin
                mem.raddr  = PTR_W'(idx_reg + 1'b1);
                state_next = S_RM_WR;
            end

            S_RM_WR:
            begin
                mem.we    = 1'b1;
                mem.waddr = idx_reg[PTR_W-1:0];
                mem.wdata = rdata;
                idx_next  = idx_reg + 1'b1;
                if ((idx_reg + CNT_W'(2)) < cnt_reg)
                begin
                    state_next = S_RM_RD;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_FINISH;
                end
            end

            // streamed sum, one read issued per cycle
            S_SUM:
            begin
                if (pend_reg)
                begin
                    res_next = alu_sum;
                end
                else
                begin
                    alu_b = val_reg;
                end
                if (idx_reg != cnt_reg)
                begin
                    mem.raddr = idx_reg[PTR_W-1:0];
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_FINISH;
                        if (!alu_eq)
                        begin
                            st_next = ST_NOT_SUM;
                        end
                        else if (cnt_reg == CNT_FULL)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            mem.we    = 1'b1;
                            mem.waddr = cnt_reg[PTR_W-1:0];
                            mem.wdata = val_reg;
                            cnt_next  = cnt_reg + 1'b1;
                        end
                    end
                end
            end

            // hand the result to the output register
            S_FINISH:
            begin
                done = out_free;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rslt.result_value = res_reg;
    assign rslt.status       = st_reg;
    assign rslt.occupancy    = OCC_W'(cnt_reg);

endmodule

>>> hw/rtl/stack_engine_with_end_ops_top.sv
// top level of the bounded lifo stack engine with end operations
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+------------------------------
//  in      | in_valid, in_ready, opcode, value         | one operation per transaction
//  out     | out_valid, out_ready, result_value,       | one result per operation
//          | status, occupancy                         |
//
// push, unused opcodes, empty pop and swap ends below two entries: a single execute step
// pop: one ram read; swap ends: two reads then two writes; reverse: that swap per pair
// remove bottom: a read and a write per shifted entry; push-if-sum: one streamed read per entry
// multi-entry operations are sequenced through the single read port of the entry ram
// reset clears the fill count, sequencer and output valid only; no ram clearing pass
// a result held on the output stalls only the final step of the next operation
module stack_engine_with_end_ops_top
    import seeo_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [OP_W-1:0]          opcode,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] result_value,
    output logic [ST_W-1:0]          status,
    output logic [OCC_W-1:0]         occupancy
);

    mem_req_t          mem;
    result_t           rslt;
    logic [DATA_W-1:0] rdata;
    logic [DATA_W-1:0] alu_a;
    logic [DATA_W-1:0] alu_b;
    logic [DATA_W-1:0] alu_sum;
    logic              alu_eq;
    logic              done;
    logic              out_free;
    logic              out_valid_reg;
    result_t           out_data_reg;

    assign out_free = !out_valid_reg || out_ready;

    // sequencer
    seeo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (opcode),
        .value    (value),
        .out_free (out_free),
        .done     (done),
        .rslt     (rslt),
        .mem      (mem),
        .rdata    (rdata),
        .alu_a    (alu_a),
        .alu_b    (alu_b),
        .alu_sum  (alu_sum),
        .alu_eq   (alu_eq)
    );

    // shared arithmetic unit
    seeo_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sum (alu_sum),
        .eq  (alu_eq)
    );

    // entry store
    seeo_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .raddr (mem.raddr),
        .rdata (rdata)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_data_reg <= rslt;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = out_data_reg.result_value;
    assign status       = out_data_reg.status;
    assign occupancy    = out_data_reg.occupancy;

endmodule

>>> hw/rtl/seeo_checker.sv
// port-level checks for the stack engine, bound to the top level
module seeo_checker
    import seeo_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic [OP_W-1:0]          opcode,
    input logic signed [DATA_W-1:0] value,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [DATA_W-1:0] result_value,
    input logic [ST_W-1:0]          status,
    input logic [OCC_W-1:0]         occupancy
);

    // a result waiting on the output holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value)
            && $stable(status) && $stable(occupancy))
        else $error("output changed while stalled");

    // the engine is busy right after taking a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accept");

    // an empty status only comes with an empty stack
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> occupancy == '0)
        else $error("empty status with entries held");

    // a full status only comes with a full stack
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> occupancy == OCC_W'(DEPTH))
        else $error("full status with room left");

endmodule

bind stack_engine_with_end_ops_top seeo_checker u_seeo_checker (.*);

>>> tb/sv/tb.sv
// self-checking testbench for the stack engine: corner cases, then random fill and drain rounds
module tb
    import seeo_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // opcodes the block treats as no operation
    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

    localparam int ITEM_TARGET = 1100;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_TAIL  = 300;
    localparam int MAX_REPORTS = 30;

    typedef enum int {GROW, SHRINK, WANDER} mix_t;

    // shadow copy of the stack that predicts each result and checks it
    class stack_mirror;
        logic [DATA_W-1:0] words [DEPTH];
        int                fill;
        result_t           due_results [$];
        int                errors;
        int                op_seen [8];
        int                peak_fill;
        int                full_hits;
        int                empty_hits;
        int                sum_hits;
        int                sum_misses;

        function new();
            fill = 0;
            errors = 0;
            peak_fill = 0;
            full_hits = 0;
            empty_hits = 0;
            sum_hits = 0;
            sum_misses = 0;
            foreach (op_seen[i]) op_seen[i] = 0;
        endfunction

        function logic [DATA_W-1:0] entry_sum();
            logic [DATA_W-1:0] total;
            total = '0;
            for (int i = 0; i < fill; i++) total += words[i];
            return total;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // apply one accepted transaction and queue the result it must produce
        function void note_op(logic [OP_W-1:0] op, logic [DATA_W-1:0] word);
            result_t           r;
            logic [DATA_W-1:0] tmp;
            logic [DATA_W-1:0] total;
            r.result_value = '0;
            r.status = ST_OK;
            op_seen[op]++;
            case (op)
                OP_PUSH:
                    if (fill == DEPTH) r.status = ST_FULL;
                    else
                    begin
                        words[fill] = word;
                        fill++;
                    end
                OP_POP:
                    if (fill == 0) r.status = ST_EMPTY;
                    else
                    begin
                        fill--;
                        r.result_value = words[fill];
                    end
                OP_REVERSE:
                    for (int i = 0; i < fill / 2; i++)
                    begin
                        tmp = words[i];
                        words[i] = words[fill - 1 - i];
                        words[fill - 1 - i] = tmp;
                    end
                OP_REMOVE_BOTTOM:
                    if (fill == 0) r.status = ST_EMPTY;
                    else
                    begin
                        for (int i = 0; i + 1 < fill; i++) words[i] = words[i + 1];
                        fill--;
                    end
                OP_SWAP_ENDS:
                    if (fill == 0) r.status = ST_EMPTY;
                    else if (fill >= 2)
                    begin
                        tmp = words[0];
                        words[0] = words[fill - 1];
                        words[fill - 1] = tmp;
                    end
                OP_PUSH_SUM:
                begin
                    total = entry_sum();
                    r.result_value = total;
                    if (word != total)
                    begin
                        r.status = ST_NOT_SUM;
                        sum_misses++;
                    end
                    else
                    begin
                        sum_hits++;
                        if (fill == DEPTH) r.status = ST_FULL;
                        else
                        begin
                            words[fill] = word;
                            fill++;
                        end
                    end
                end
                default: ;
            endcase
            if (r.status == ST_FULL) full_hits++;
            if (r.status == ST_EMPTY) empty_hits++;
            if (fill > peak_fill) peak_fill = fill;
            r.occupancy = OCC_W'(fill);
            due_results.push_back(r);
        endfunction

        function void report(string what, longint expd, longint act);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, expd, act);
        endfunction

        // compare one result transaction with the oldest prediction
        function void check_result(logic signed [DATA_W-1:0] rv, logic [ST_W-1:0] st,
                                   logic [OCC_W-1:0] occ);
            result_t e;
            if (due_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected nothing, actual %0d/%0d/%0d",
                         $time, rv, st, occ);
                return;
            end
            e = due_results.pop_front();
            if (rv !== e.result_value) report("result_value", e.result_value, rv);
            if (st !== e.status) report("status", e.status, st);
            if (occ !== e.occupancy) report("occupancy", e.occupancy, occ);
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] result_value;
    logic [ST_W-1:0]          status;
    logic [OCC_W-1:0]         occupancy;

    stack_mirror mirror = new();

    int items_sent  = 0;
    int burst_left  = 0;
    int holds_asked = 0;
    int holds_done  = 0;
    int hold_left   = 0;
    int rx_cycle    = 0;

    stack_engine_with_end_ops_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .status       (status),
        .occupancy    (occupancy)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // output side: long hold when asked, otherwise a rotating stall pattern
    always @(negedge clk)
    begin
        rx_cycle++;
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (holds_done < holds_asked)
        begin
            holds_done++;
            hold_left = LONG_HOLD - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            case ((rx_cycle / 97) % 4)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 9) < 7);
                2:       out_ready <= ((rx_cycle % 7) >= 3);
                default: out_ready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            mirror.check_result(result_value, status, occupancy);
    end

    // offer one transaction; entered and left just after a falling edge
    task automatic send_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] word);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        opcode <= op;
        value <= word;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        mirror.note_op(op, word);
        items_sent++;
        @(negedge clk);
    endtask

    // stop offering until every predicted result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (mirror.pending() != 0);
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // one random transaction, opcode mix biased by the current phase
    task automatic gen_item(input mix_t mix);
        int                roll;
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] word;
        roll = $urandom_range(0, 99);
        op = OP_PUSH;
        case (mix)
            GROW:
                if (roll < 65) op = OP_PUSH;
                else if (roll < 80) op = OP_PUSH_SUM;
                else if (roll < 85) op = OP_POP;
                else if (roll < 90) op = OP_REVERSE;
                else if (roll < 94) op = OP_SWAP_ENDS;
                else if (roll < 97) op = OP_REMOVE_BOTTOM;
                else op = ($urandom_range(0, 1) != 0) ? OP_UNUSED_7 : OP_UNUSED_6;
            SHRINK:
                if (roll < 35) op = OP_POP;
                else if (roll < 60) op = OP_REMOVE_BOTTOM;
                else if (roll < 70) op = OP_PUSH;
                else if (roll < 78) op = OP_REVERSE;
                else if (roll < 86) op = OP_SWAP_ENDS;
                else if (roll < 94) op = OP_PUSH_SUM;
                else op = ($urandom_range(0, 1) != 0) ? OP_UNUSED_7 : OP_UNUSED_6;
            default:
                op = OP_W'($urandom_range(OP_PUSH, OP_UNUSED_7));
        endcase
        word = pick_word();
        if (op == OP_PUSH_SUM && $urandom_range(0, 3) != 0) word = mirror.entry_sum();
        send_op(op, word);
    endtask

    // end the run if it hangs
    initial
    begin
        #20_000_000;
        $display("** stack_engine_with_end_ops_top: FAILED **");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_PUSH;
        value = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // corner cases on an empty, single and small stack
        send_op(OP_POP, 32'h1234_5678);
        send_op(OP_REMOVE_BOTTOM, '0);
        send_op(OP_SWAP_ENDS, '0);
        send_op(OP_REVERSE, '0);
        send_op(OP_PUSH_SUM, '0);
        send_op(OP_PUSH_SUM, 32'd5);
        send_op(OP_SWAP_ENDS, 32'hffff_ffff);
        send_op(OP_REVERSE, 32'hffff_ffff);
        send_op(OP_UNUSED_6, 32'h5555_aaaa);
        send_op(OP_UNUSED_7, 32'hffff_ffff);
        send_op(OP_PUSH, 32'h8000_0000);
        send_op(OP_PUSH, 32'h7fff_ffff);
        send_op(OP_PUSH, 32'hffff_ffff);
        send_op(OP_PUSH_SUM, mirror.entry_sum());
        send_op(OP_REVERSE, '0);
        send_op(OP_SWAP_ENDS, '0);
        send_op(OP_REMOVE_BOTTOM, '0);
        send_op(OP_REVERSE, '0);
        send_op(OP_POP, '0);
        send_op(OP_PUSH_SUM, mirror.entry_sum() + 1);
        repeat (4) send_op(OP_POP, $urandom());
        wait_drained();

        // random rounds: grow to full, wander, shrink to empty
        while (items_sent < ITEM_TARGET)
        begin
            while (mirror.fill < DEPTH) gen_item(GROW);
            send_op(OP_PUSH_SUM, mirror.entry_sum());
            send_op(OP_PUSH, pick_word());
            repeat (10) gen_item(GROW);
            holds_asked++;
            repeat (100) gen_item(WANDER);
            while (mirror.fill > 0) gen_item(SHRINK);
            repeat (8) gen_item(SHRINK);
            wait_drained();
        end

        in_valid <= 1'b0;
        while (mirror.pending() != 0) @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("covered %0d transactions: push %0d, pop %0d, reverse %0d, remove bottom %0d,",
                 items_sent, mirror.op_seen[OP_PUSH], mirror.op_seen[OP_POP],
                 mirror.op_seen[OP_REVERSE], mirror.op_seen[OP_REMOVE_BOTTOM]);
        $display("swap ends %0d, push-if-sum %0d (%0d matched), no-op %0d; peak depth %0d,",
                 mirror.op_seen[OP_SWAP_ENDS], mirror.op_seen[OP_PUSH_SUM], mirror.sum_hits,
                 mirror.op_seen[OP_UNUSED_6] + mirror.op_seen[OP_UNUSED_7], mirror.peak_fill);
        $display("%0d full and %0d empty statuses seen", mirror.full_hits, mirror.empty_hits);
        if (mirror.errors == 0 && mirror.pending() == 0)
            $display("** stack_engine_with_end_ops_top: PASSED **");
        else
            $display("** stack_engine_with_end_ops_top: FAILED **");
        $finish;
    end

endmodule
